/* src/sort_array_ascending_assert.svh */
// Assertion macros used by the sorter top level.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SORT_ARRAY_ASCENDING_ASSERT_SVH
`define SORT_ARRAY_ASCENDING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SAA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter assertion failed");

`endif

/* src/saa_pkg.sv */
package saa_pkg;

    // Store depth, which is the number of cells in the chain (valid range 2 to 64).
    localparam int unsigned DEPTH = 64;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned VAL_W = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_res;
        logic                    last_res;
        logic                    overflow;
    } out_item_t;

    // One token travelling along the chain or held in a cell.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] value;
    } cell_tok_t;

    typedef struct packed {
        logic shift;
    } cell_ctl_t;

endpackage

/* src/sort_array_ascending.sv */
// Loading takes one item per cycle; the set is then sorted while in-flight values settle.
// Throughput: results leave at one per cycle when the consumer is ready.
// The drain time is set by the longest walk of a value along the chain of cells.
// Reset (rst_n, asynchronous, active low) empties all cells and clears count and flag;
// no clearing pass is needed, so the block accepts items straight after reset.
`include "sort_array_ascending_assert.svh"

module sort_array_ascending (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  saa_pkg::in_item_t  item,
    output logic               res_valid,
    input  logic               res_ready,
    output saa_pkg::out_item_t res
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [saa_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        dropped_reg, dropped_next;

    saa_pkg::cell_tok_t          feed_tok  [saa_pkg::DEPTH];
    saa_pkg::cell_tok_t          held_tok  [saa_pkg::DEPTH];
    saa_pkg::cell_tok_t          pass_tok  [saa_pkg::DEPTH];
    saa_pkg::cell_tok_t          shift_tok [saa_pkg::DEPTH];
    logic [saa_pkg::DEPTH-1:0]   pass_vld;
    saa_pkg::cell_ctl_t          cell_ctl;

    logic in_xfer;
    logic out_xfer;
    logic full;
    logic inject;

    assign item_ready = (state_reg == ST_LOAD);
    assign in_xfer    = item_valid && item_ready;
    assign full       = (count_reg == saa_pkg::CNT_W'(saa_pkg::DEPTH));
    // A value enters the chain only while there is still room for it; once the
    // store is full, arriving values are dropped and the overflow flag is raised.
    assign inject     = in_xfer && !full;

    assign res_valid  = (state_reg == ST_EMIT);
    assign out_xfer   = res_valid && res_ready;

    // During emission the whole chain moves one cell to the left on each
    // transfer, so cell 0 always holds the smallest remaining value.
    assign cell_ctl.shift = out_xfer;

    assign feed_tok[0].vld   = inject;
    assign feed_tok[0].value = item.value;

    genvar gi;
    generate
        for (gi = 0; gi < saa_pkg::DEPTH; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_feed
                assign feed_tok[gi] = pass_tok[gi-1];
            end
            if (gi < saa_pkg::DEPTH - 1)
            begin : g_shift
                assign shift_tok[gi] = held_tok[gi+1];
            end
            else
            begin : g_shift_end
                assign shift_tok[gi].vld   = 1'b0;
                assign shift_tok[gi].value = '0;
            end

            saa_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .feed     (feed_tok[gi]),
                .shift_in (shift_tok[gi]),
                .held     (held_tok[gi]),
                .pass     (pass_tok[gi])
            );

            assign pass_vld[gi] = pass_tok[gi].vld;
        end
    endgenerate

    // The result of the current cell 0. It is the final result when the next
    // cell holds nothing.
    assign res.value_res = held_tok[0].value;
    assign res.last_res  = !held_tok[1].vld;
    assign res.overflow  = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + saa_pkg::CNT_W'(1);
                    end
                    if (item.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Sorting is complete once no value is still moving between cells.
                if (~|pass_vld)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer && res.last_res)
                begin
                    state_next   = ST_LOAD;
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    `SAA_ASSERT_SAME(a_emit_has_value, state_reg == ST_EMIT, held_tok[0].vld)
    `SAA_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= saa_pkg::CNT_W'(saa_pkg::DEPTH))
    `SAA_ASSERT_SAME(a_emit_ordered, state_reg == ST_EMIT && held_tok[1].vld,
        held_tok[0].value <= held_tok[1].value)
    `SAA_ASSERT_NEXT(a_set_cleared, out_xfer && res.last_res,
        count_reg == '0 && !dropped_reg && !held_tok[0].vld)

endmodule

/* src/saa_cell.sv */
module saa_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  saa_pkg::cell_ctl_t ctl,
    input  saa_pkg::cell_tok_t feed,
    input  saa_pkg::cell_tok_t shift_in,
    output saa_pkg::cell_tok_t held,
    output saa_pkg::cell_tok_t pass
);

    logic                            held_vld_reg, held_vld_next;
    logic signed [saa_pkg::VAL_W-1:0] held_val_reg, held_val_next;
    logic                            pass_vld_reg, pass_vld_next;
    logic signed [saa_pkg::VAL_W-1:0] pass_val_reg, pass_val_next;

    // The cell keeps the smaller of its held value and the arriving one and
    // passes the larger one on to its right-hand neighbour.
    always_comb
    begin
        held_vld_next = held_vld_reg;
        held_val_next = held_val_reg;
        pass_vld_next = 1'b0;
        pass_val_next = pass_val_reg;
        if (ctl.shift)
        begin
            held_vld_next = shift_in.vld;
            held_val_next = shift_in.value;
        end
        else if (feed.vld)
        begin
            if (!held_vld_reg)
            begin
                held_vld_next = 1'b1;
                held_val_next = feed.value;
            end
            else if (feed.value < held_val_reg)
            begin
                held_val_next = feed.value;
                pass_vld_next = 1'b1;
                pass_val_next = held_val_reg;
            end
            else
            begin
                pass_vld_next = 1'b1;
                pass_val_next = feed.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            held_vld_reg <= held_vld_next;
            pass_vld_reg <= pass_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_val_reg <= held_val_next;
        pass_val_reg <= pass_val_next;
    end

    assign held.vld   = held_vld_reg;
    assign held.value = held_val_reg;
    assign pass.vld   = pass_vld_reg;
    assign pass.value = pass_val_reg;

endmodule
